>>> rtl/gcol_pkg.sv
// Shared types and constants for the greedy graph coloring unit.
// No dependencies; used by every module under rtl/ except gcol_vtx_mem.
package gcol_pkg;

    localparam int OPCODE_W = 2;
    localparam int VID_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COLOR_W  = 6;
    localparam int VCNT_W   = 9;

    localparam logic [VCNT_W-1:0]  VCNT_RESET = 9'd256;
    localparam logic [COLOR_W-1:0] COLOR_NONE = 6'h3F;   // -1, uncolored

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_COLOR = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_RANGE = 3'd2,
        ST_FULL  = 3'd3,
        ST_LOOP  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_RDA,
        S_RDB,
        S_SCAN,
        S_WRA,
        S_WRB,
        S_WALK,
        S_PICK,
        S_EMIT
    } t_state;

endpackage

>>> rtl/gcol_nbr_mem.sv
// Neighbor list RAM: one row of slots per vertex, synchronous read with registered output.
// Uses gcol_pkg for the vertex id width.
module gcol_nbr_mem #(
    parameter int AW = 12
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [gcol_pkg::VID_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [gcol_pkg::VID_W-1:0] o_rdata
);

    logic [gcol_pkg::VID_W-1:0] mem [0:(1<<AW)-1];
    logic [gcol_pkg::VID_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> rtl/gcol_vtx_mem.sv
// Per-vertex state RAM (degree, colored flag, color) with a valid bit per entry.
// An entry never written since reset or clear reads as all zero. Uses no package items.
module gcol_vtx_mem #(
    parameter int DEPTH = 256,
    parameter int W     = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clr,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0]     mem [0:DEPTH-1];
    logic [W-1:0]     r_q;
    logic [DEPTH-1:0] r_vld;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q      <= mem[i_raddr];
        r_rd_vld <= r_vld[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // invalid entry = degree 0, uncolored
    assign o_rdata = r_rd_vld ? r_q : '0;

endmodule

>>> rtl/gcol_ctrl.sv
// Sequencer for the graph coloring unit: decodes items, walks neighbor lists in the
// RAMs, holds the vertex_count register and the output register. Uses gcol_pkg.
module gcol_ctrl #(
    parameter int NUM_V   = 256,
    parameter int MAX_DEG = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [gcol_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [gcol_pkg::VID_W-1:0]        i_vertex_a,
    input  logic [gcol_pkg::VID_W-1:0]        i_vertex_b,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gcol_pkg::STATUS_W-1:0]     o_status,
    output logic [gcol_pkg::COLOR_W-1:0]      o_color,
    input  logic                              i_cfg_we,
    input  logic [gcol_pkg::VCNT_W-1:0]       i_cfg_wdata,
    output logic                              o_nt_we,
    output logic [$clog2(NUM_V)+((MAX_DEG > 1) ? $clog2(MAX_DEG) : 1)-1:0] o_nt_waddr,
    output logic [gcol_pkg::VID_W-1:0]        o_nt_wdata,
    output logic [$clog2(NUM_V)+((MAX_DEG > 1) ? $clog2(MAX_DEG) : 1)-1:0] o_nt_raddr,
    input  logic [gcol_pkg::VID_W-1:0]        i_nt_rdata,
    output logic                              o_vs_clr,
    output logic                              o_vs_we,
    output logic [$clog2(NUM_V)-1:0]          o_vs_waddr,
    output logic [2*$clog2(MAX_DEG+1):0]      o_vs_wdata,
    output logic [$clog2(NUM_V)-1:0]          o_vs_raddr,
    input  logic [2*$clog2(MAX_DEG+1):0]      i_vs_rdata
);

    localparam int VW  = $clog2(NUM_V);
    localparam int IW  = (MAX_DEG > 1) ? $clog2(MAX_DEG) : 1;
    localparam int DW  = $clog2(MAX_DEG + 1);
    localparam int CW  = DW;
    localparam int VSW = DW + 1 + CW;

    localparam logic [DW-1:0] DMAX = DW'(MAX_DEG);
    localparam logic [gcol_pkg::VCNT_W-1:0] NV_LIM = gcol_pkg::VCNT_W'(NUM_V);

    gcol_pkg::t_state  r_state, n_state;
    gcol_pkg::t_opcode r_op;
    gcol_pkg::t_status r_res_status, r_out_status;

    logic [gcol_pkg::VID_W-1:0]   r_a, r_b;
    logic [gcol_pkg::VCNT_W-1:0]  r_vcount;
    logic [DW-1:0]                r_deg_a, r_deg_b, r_idx;
    logic [CW:0]                  r_col_a, r_col_b;   // {colored, color}
    logic                         r_p1, r_p2;
    logic [MAX_DEG-1:0]           r_used;
    logic [gcol_pkg::COLOR_W-1:0] r_res_color, r_out_color;
    logic                         r_out_valid;

    logic [DW-1:0] vs_deg;
    logic          vs_cold;
    logic [CW-1:0] vs_col;
    logic          acc, a_ok, b_ok, hit, scan_done, walk_done, full, issue, out_free;
    logic [CW-1:0] pick;

    assign vs_deg  = i_vs_rdata[VSW-1 -: DW];
    assign vs_cold = i_vs_rdata[CW];
    assign vs_col  = i_vs_rdata[CW-1:0];

    assign acc       = i_in_valid && (r_state == gcol_pkg::S_IDLE);
    assign a_ok      = ({1'b0, r_a} < r_vcount) && ({1'b0, r_a} < NV_LIM);
    assign b_ok      = ({1'b0, r_b} < r_vcount) && ({1'b0, r_b} < NV_LIM);
    assign hit       = r_p1 && (i_nt_rdata == r_b);
    assign scan_done = (r_idx == r_deg_a) && !r_p1;
    assign walk_done = (r_idx == r_deg_a) && !r_p1 && !r_p2;
    assign full      = (r_deg_a == DMAX) || (r_deg_b == DMAX);
    assign issue     = (r_idx != r_deg_a);
    assign out_free  = !r_out_valid || !i_out_stall;

    // first color not held by a neighbor
    always_comb begin
        pick = CW'(MAX_DEG);
        for (int i = MAX_DEG - 1; i >= 0; i--) begin
            if (!r_used[i]) pick = CW'(i);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gcol_pkg::S_IDLE: if (acc) n_state = gcol_pkg::S_DEC;
            gcol_pkg::S_DEC: begin
                if (r_op == gcol_pkg::OP_CLEAR) n_state = gcol_pkg::S_EMIT;
                else if (!a_ok || (r_op == gcol_pkg::OP_ADD && !b_ok)) n_state = gcol_pkg::S_EMIT;
                else n_state = gcol_pkg::S_RDA;
            end
            gcol_pkg::S_RDA: begin
                unique case (r_op)
                    gcol_pkg::OP_ADD:   n_state = (r_a == r_b) ? gcol_pkg::S_EMIT : gcol_pkg::S_RDB;
                    gcol_pkg::OP_COLOR: n_state = gcol_pkg::S_WALK;
                    default:            n_state = gcol_pkg::S_EMIT;
                endcase
            end
            gcol_pkg::S_RDB: n_state = gcol_pkg::S_SCAN;
            gcol_pkg::S_SCAN: begin
                if (hit) n_state = gcol_pkg::S_EMIT;
                else if (scan_done) n_state = full ? gcol_pkg::S_EMIT : gcol_pkg::S_WRA;
            end
            gcol_pkg::S_WRA:  n_state = gcol_pkg::S_WRB;
            gcol_pkg::S_WRB:  n_state = gcol_pkg::S_EMIT;
            gcol_pkg::S_WALK: if (walk_done) n_state = gcol_pkg::S_PICK;
            gcol_pkg::S_PICK: n_state = gcol_pkg::S_EMIT;
            gcol_pkg::S_EMIT: if (out_free) n_state = gcol_pkg::S_IDLE;
            default:          n_state = gcol_pkg::S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        o_nt_we    = 1'b0;
        o_nt_waddr = {r_a[VW-1:0], r_deg_a[IW-1:0]};
        o_nt_wdata = r_b;
        o_nt_raddr = {r_a[VW-1:0], r_idx[IW-1:0]};
        o_vs_clr   = 1'b0;
        o_vs_we    = 1'b0;
        o_vs_waddr = r_a[VW-1:0];
        o_vs_wdata = {r_deg_a + DW'(1), r_col_a};
        o_vs_raddr = r_a[VW-1:0];
        unique case (r_state)
            gcol_pkg::S_DEC: o_vs_clr = (r_op == gcol_pkg::OP_CLEAR);
            gcol_pkg::S_RDA: o_vs_raddr = r_b[VW-1:0];
            gcol_pkg::S_WRA: begin
                o_nt_we = 1'b1;
                o_vs_we = 1'b1;
            end
            gcol_pkg::S_WRB: begin
                o_nt_we    = 1'b1;
                o_nt_waddr = {r_b[VW-1:0], r_deg_b[IW-1:0]};
                o_nt_wdata = r_a;
                o_vs_we    = 1'b1;
                o_vs_waddr = r_b[VW-1:0];
                o_vs_wdata = {r_deg_b + DW'(1), r_col_b};
            end
            gcol_pkg::S_WALK: o_vs_raddr = i_nt_rdata[VW-1:0];
            gcol_pkg::S_PICK: begin
                o_vs_we    = 1'b1;
                o_vs_wdata = {r_deg_a, 1'b1, pick};
            end
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != gcol_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gcol_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_vcount    <= gcol_pkg::VCNT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_vcount <= i_cfg_wdata;
            if (r_state == gcol_pkg::S_EMIT && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op <= gcol_pkg::t_opcode'(i_opcode);
            r_a  <= i_vertex_a;
            r_b  <= i_vertex_b;
        end
        case (r_state)
            gcol_pkg::S_DEC: begin
                r_res_color  <= gcol_pkg::COLOR_NONE;
                r_res_status <= (r_op != gcol_pkg::OP_CLEAR &&
                                 (!a_ok || (r_op == gcol_pkg::OP_ADD && !b_ok)))
                                ? gcol_pkg::ST_RANGE : gcol_pkg::ST_OK;
            end
            gcol_pkg::S_RDA: begin
                r_deg_a      <= vs_deg;
                r_col_a      <= {vs_cold, vs_col};
                r_idx        <= '0;
                r_p1         <= 1'b0;
                r_p2         <= 1'b0;
                r_used       <= '0;
                r_res_color  <= vs_cold ? gcol_pkg::COLOR_W'(vs_col) : gcol_pkg::COLOR_NONE;
                r_res_status <= (r_op == gcol_pkg::OP_ADD && r_a == r_b)
                                ? gcol_pkg::ST_LOOP : gcol_pkg::ST_OK;
            end
            gcol_pkg::S_RDB: begin
                r_deg_b <= vs_deg;
                r_col_b <= {vs_cold, vs_col};
            end
            gcol_pkg::S_SCAN: begin
                r_idx <= r_idx + DW'(issue);
                r_p1  <= issue;
                if (hit) r_res_status <= gcol_pkg::ST_DUP;
                else if (scan_done && full) r_res_status <= gcol_pkg::ST_FULL;
            end
            gcol_pkg::S_WALK: begin
                // neighbor id in flight on p1, its state arrives on p2
                r_idx <= r_idx + DW'(issue);
                r_p1  <= issue;
                r_p2  <= r_p1;
                if (r_p2 && vs_cold && vs_col < CW'(MAX_DEG)) r_used[vs_col[IW-1:0]] <= 1'b1;
            end
            gcol_pkg::S_PICK: r_res_color <= gcol_pkg::COLOR_W'(pick);
            gcol_pkg::S_EMIT: begin
                if (out_free) begin
                    r_out_status <= r_res_status;
                    r_out_color  <= r_res_color;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_color     = r_out_color;

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gcol_pkg::S_SCAN || r_state == gcol_pkg::S_WALK) |-> r_idx <= r_deg_a)
        else $error("neighbor walk index passed degree");

    a_nt_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nt_we |-> (((r_state == gcol_pkg::S_WRA) ? r_deg_a : r_deg_b) < DMAX))
        else $error("neighbor write into a full list");

    a_walk_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gcol_pkg::S_PICK) |-> (!r_p1 && !r_p2))
        else $error("color chosen with neighbor reads in flight");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == gcol_pkg::S_EMIT)
        else $error("result loaded outside of emit");
`endif

endmodule

>>> rtl/greedy_graph_coloring_unit.sv
// Greedy first-fit graph coloring unit: top level with sequencer and two RAMs.
// Items run one at a time: the input stalls from accept until the result register loads.
// Neighbor walks read one list slot per cycle; degree sets the item time.
// Reset (sync, active low): vertex_count = 256, all vertex valid bits cleared at once.
module greedy_graph_coloring_unit #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_DEGREE   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [gcol_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic [gcol_pkg::VID_W-1:0]       i_vertex_a,
    input  logic [gcol_pkg::VID_W-1:0]       i_vertex_b,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [gcol_pkg::STATUS_W-1:0]    o_status,
    output logic signed [gcol_pkg::COLOR_W-1:0] o_color,
    input  logic                             i_cfg_we,
    input  logic [gcol_pkg::VCNT_W-1:0]      i_cfg_wdata
);

    // ids are 8 bits wide, so no more than 256 vertices are reachable
    localparam int NV  = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
    localparam int VW  = $clog2(NV);
    localparam int IW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int VSW = 2 * DW + 1;

    logic                       nt_we;
    logic [VW+IW-1:0]           nt_waddr, nt_raddr;
    logic [gcol_pkg::VID_W-1:0] nt_wdata, nt_rdata;
    logic                       vs_clr, vs_we;
    logic [VW-1:0]              vs_waddr, vs_raddr;
    logic [VSW-1:0]             vs_wdata, vs_rdata;
    logic [gcol_pkg::COLOR_W-1:0] color;

    gcol_ctrl #(
        .NUM_V   (NV),
        .MAX_DEG (MAX_DEGREE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_color     (color),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_nt_we     (nt_we),
        .o_nt_waddr  (nt_waddr),
        .o_nt_wdata  (nt_wdata),
        .o_nt_raddr  (nt_raddr),
        .i_nt_rdata  (nt_rdata),
        .o_vs_clr    (vs_clr),
        .o_vs_we     (vs_we),
        .o_vs_waddr  (vs_waddr),
        .o_vs_wdata  (vs_wdata),
        .o_vs_raddr  (vs_raddr),
        .i_vs_rdata  (vs_rdata)
    );

    gcol_nbr_mem #(
        .AW (VW + IW)
    ) u_nbr_mem (
        .i_clk   (i_clk),
        .i_we    (nt_we),
        .i_waddr (nt_waddr),
        .i_wdata (nt_wdata),
        .i_raddr (nt_raddr),
        .o_rdata (nt_rdata)
    );

    gcol_vtx_mem #(
        .DEPTH (NV),
        .W     (VSW)
    ) u_vtx_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (vs_clr),
        .i_we    (vs_we),
        .i_waddr (vs_waddr),
        .i_wdata (vs_wdata),
        .i_raddr (vs_raddr),
        .o_rdata (vs_rdata)
    );

    assign o_color = $signed(color);

endmodule

>>> test/greedy_graph_coloring_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for greedy_graph_coloring_unit: directed and random items
// checked against an in-bench copy of the graph. Depends on gcol_pkg and the unit RTL.
module greedy_graph_coloring_unit_tb;

    localparam int NV           = 256;
    localparam int MAXD         = 16;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOT_SPAN     = 24;

    typedef struct packed {
        gcol_pkg::t_status                status;
        logic [gcol_pkg::COLOR_W-1:0]     color;
    } t_result;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic [gcol_pkg::OPCODE_W-1:0]       i_opcode;
    logic [gcol_pkg::VID_W-1:0]          i_vertex_a;
    logic [gcol_pkg::VID_W-1:0]          i_vertex_b;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic [gcol_pkg::STATUS_W-1:0]       o_status;
    logic signed [gcol_pkg::COLOR_W-1:0] o_color;
    logic                                i_cfg_we;
    logic [gcol_pkg::VCNT_W-1:0]         i_cfg_wdata;

    // graph copy kept by the bench
    logic [gcol_pkg::VID_W-1:0]   nbr_list  [NV][MAXD];
    int unsigned                  nbr_deg   [NV];
    logic [gcol_pkg::COLOR_W-1:0] vtx_color [NV];
    logic [gcol_pkg::VCNT_W-1:0]  vcount;

    t_result owed_results[$];
    t_result front_res;

    int send_idle_pct;
    int stall_pct;
    int err_count;
    int items_sent;
    int results_checked;
    int quiet_cycles;
    int status_tally [8];

    greedy_graph_coloring_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_color     (o_color),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------- graph prediction ----------------

    function automatic logic vertex_in_use(logic [gcol_pkg::VID_W-1:0] v);
        return ({1'b0, v} < vcount);
    endfunction

    function automatic void graph_clear();
        for (int i = 0; i < NV; i++) begin
            nbr_deg[i]   = 0;
            vtx_color[i] = gcol_pkg::COLOR_NONE;
        end
    endfunction

    function automatic gcol_pkg::t_status graph_link(logic [gcol_pkg::VID_W-1:0] a,
                                                     logic [gcol_pkg::VID_W-1:0] b);
        if (a == b)
            return gcol_pkg::ST_LOOP;
        for (int i = 0; i < nbr_deg[a]; i++)
            if (nbr_list[a][i] == b)
                return gcol_pkg::ST_DUP;
        if (nbr_deg[a] >= MAXD || nbr_deg[b] >= MAXD)
            return gcol_pkg::ST_FULL;
        nbr_list[a][nbr_deg[a]] = b;
        nbr_list[b][nbr_deg[b]] = a;
        nbr_deg[a]++;
        nbr_deg[b]++;
        return gcol_pkg::ST_OK;
    endfunction

    // first fit: smallest color no colored neighbor holds, capped at MAXD
    function automatic void graph_first_fit(logic [gcol_pkg::VID_W-1:0] v);
        logic [MAXD:0]                taken;
        logic [gcol_pkg::COLOR_W-1:0] nc;
        int                           c;
        taken = '0;
        for (int i = 0; i < nbr_deg[v]; i++) begin
            nc = vtx_color[nbr_list[v][i]];
            if (!nc[gcol_pkg::COLOR_W-1] && nc <= MAXD)
                taken[nc] = 1'b1;
        end
        c = 0;
        while (c < MAXD && taken[c])
            c++;
        vtx_color[v] = gcol_pkg::COLOR_W'(c);
    endfunction

    function automatic t_result graph_apply(gcol_pkg::t_opcode op,
                                            logic [gcol_pkg::VID_W-1:0] a,
                                            logic [gcol_pkg::VID_W-1:0] b);
        t_result r;
        r.status = gcol_pkg::ST_OK;
        r.color  = gcol_pkg::COLOR_NONE;
        case (op)
            gcol_pkg::OP_CLEAR: graph_clear();
            gcol_pkg::OP_ADD: begin
                if (!vertex_in_use(a) || !vertex_in_use(b)) begin
                    r.status = gcol_pkg::ST_RANGE;
                end else begin
                    r.status = graph_link(a, b);
                    r.color  = vtx_color[a];
                end
            end
            default: begin
                if (!vertex_in_use(a)) begin
                    r.status = gcol_pkg::ST_RANGE;
                end else begin
                    if (op == gcol_pkg::OP_COLOR)
                        graph_first_fit(a);
                    r.color = vtx_color[a];
                end
            end
        endcase
        return r;
    endfunction

    // ---------------- result side ----------------

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
                 $time, what, results_checked, got, want);
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result", o_status, -2);
            end else begin
                front_res = owed_results.pop_front();
                if (o_status !== front_res.status)
                    report_mismatch("status", o_status, front_res.status);
                if (o_color !== front_res.color)
                    report_mismatch("color", $signed(o_color), $signed(front_res.color));
                status_tally[front_res.status]++;
            end
            results_checked++;
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- input side ----------------

    task automatic send_item(gcol_pkg::t_opcode op, logic [gcol_pkg::VID_W-1:0] a,
                             logic [gcol_pkg::VID_W-1:0] b);
        t_result exp_res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_vertex_a <= a;
        i_vertex_b <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        exp_res      = graph_apply(op, a, b);
        owed_results = {owed_results, exp_res};
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(logic [gcol_pkg::VCNT_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        vcount = value;
    endtask

    function automatic logic [gcol_pkg::VID_W-1:0] pick_vertex(int base);
        if ($urandom_range(0, 99) < 85)
            return gcol_pkg::VID_W'(base + $urandom_range(0, HOT_SPAN - 1));
        return gcol_pkg::VID_W'($urandom_range(0, NV - 1));
    endfunction

    // ---------------- tests ----------------

    task automatic test_basic_ops();
        send_item(gcol_pkg::OP_CLEAR, 8'd0, 8'd0);
        send_item(gcol_pkg::OP_READ,  8'd0, 8'd0);
        send_item(gcol_pkg::OP_COLOR, 8'd0, 8'd0);
        send_item(gcol_pkg::OP_ADD,   8'd0, 8'd255);
        send_item(gcol_pkg::OP_ADD,   8'd255, 8'd0);     // duplicate from the other end
        send_item(gcol_pkg::OP_ADD,   8'd7, 8'd7);       // self-loop
        send_item(gcol_pkg::OP_COLOR, 8'd255, 8'd0);
        send_item(gcol_pkg::OP_READ,  8'd255, 8'd0);
        send_item(gcol_pkg::OP_ADD,   8'd0, 8'd128);
        send_item(gcol_pkg::OP_COLOR, 8'd128, 8'd0);
        send_item(gcol_pkg::OP_COLOR, 8'd0, 8'd0);       // recolor, own old color ignored
        send_item(gcol_pkg::OP_ADD,   8'd170, 8'd85);
        send_item(gcol_pkg::OP_COLOR, 8'd85, 8'd0);
        send_item(gcol_pkg::OP_READ,  8'd200, 8'd0);
        send_item(gcol_pkg::OP_CLEAR, 8'd255, 8'd255);
        send_item(gcol_pkg::OP_READ,  8'd0, 8'd0);
        send_item(gcol_pkg::OP_READ,  8'd255, 8'd0);
    endtask

    // 17-clique fills every list and drives the top color to MAXD
    task automatic test_full_list_and_max_color();
        for (int i = 100; i < 117; i++)
            for (int j = i + 1; j < 117; j++)
                send_item(gcol_pkg::OP_ADD, gcol_pkg::VID_W'(i), gcol_pkg::VID_W'(j));
        send_item(gcol_pkg::OP_ADD, 8'd100, 8'd117);     // a side full
        send_item(gcol_pkg::OP_ADD, 8'd117, 8'd101);     // b side full
        send_item(gcol_pkg::OP_ADD, 8'd101, 8'd100);     // duplicate wins over full
        for (int i = 100; i < 117; i++)
            send_item(gcol_pkg::OP_COLOR, gcol_pkg::VID_W'(i), 8'd0);
        send_item(gcol_pkg::OP_COLOR, 8'd100, 8'd0);
        send_item(gcol_pkg::OP_COLOR, 8'd116, 8'd0);
        send_item(gcol_pkg::OP_READ,  8'd116, 8'd0);
    endtask

    task automatic test_range_and_count();
        write_vertex_count(9'd1);
        send_item(gcol_pkg::OP_ADD,   8'd0, 8'd1);
        send_item(gcol_pkg::OP_ADD,   8'd1, 8'd0);
        send_item(gcol_pkg::OP_ADD,   8'd0, 8'd0);
        send_item(gcol_pkg::OP_COLOR, 8'd0, 8'd0);
        send_item(gcol_pkg::OP_READ,  8'd1, 8'd0);
        send_item(gcol_pkg::OP_COLOR, 8'd255, 8'd0);
        write_vertex_count(9'd0);
        send_item(gcol_pkg::OP_READ,  8'd0, 8'd0);
        send_item(gcol_pkg::OP_ADD,   8'd0, 8'd0);
        send_item(gcol_pkg::OP_CLEAR, 8'd0, 8'd0);
        write_vertex_count(9'd511);            // acts as the full vertex range
        send_item(gcol_pkg::OP_ADD,   8'd255, 8'd254);
        send_item(gcol_pkg::OP_COLOR, 8'd255, 8'd0);
        send_item(gcol_pkg::OP_COLOR, 8'd254, 8'd0);
        write_vertex_count(9'd256);
    endtask

    task automatic test_stale_neighbors();
        send_item(gcol_pkg::OP_CLEAR, 8'd0, 8'd0);
        send_item(gcol_pkg::OP_ADD,   8'd10, 8'd200);
        send_item(gcol_pkg::OP_ADD,   8'd10, 8'd201);
        send_item(gcol_pkg::OP_COLOR, 8'd200, 8'd0);
        send_item(gcol_pkg::OP_COLOR, 8'd201, 8'd0);
        write_vertex_count(9'd100);
        send_item(gcol_pkg::OP_COLOR, 8'd10, 8'd0);      // neighbors above the count still block
        send_item(gcol_pkg::OP_READ,  8'd200, 8'd0);
        send_item(gcol_pkg::OP_ADD,   8'd10, 8'd200);
        write_vertex_count(9'd256);
    endtask

    task automatic test_random_traffic(int n_items);
        int                         base;
        int                         roll;
        logic [gcol_pkg::VID_W-1:0] a;
        logic [gcol_pkg::VID_W-1:0] b;
        gcol_pkg::t_opcode          op;
        base = $urandom_range(0, NV - HOT_SPAN);
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 999);
            if (roll < 8)
                op = gcol_pkg::OP_CLEAR;
            else if (roll < 480)
                op = gcol_pkg::OP_ADD;
            else if (roll < 800)
                op = gcol_pkg::OP_COLOR;
            else
                op = gcol_pkg::OP_READ;
            a = pick_vertex(base);
            b = pick_vertex(base);
            if (k % 150 == 149)
                base = $urandom_range(0, NV - HOT_SPAN);
            send_item(op, a, b);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = '0;
        i_vertex_a    = '0;
        i_vertex_b    = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        send_idle_pct = 16;
        stall_pct     = 53;
        err_count     = 0;
        items_sent    = 0;
        results_checked = 0;
        quiet_cycles  = 0;
        foreach (status_tally[i])
            status_tally[i] = 0;
        vcount = gcol_pkg::VCNT_RESET;
        graph_clear();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_full_list_and_max_color();
        test_range_and_count();
        test_stale_neighbors();
        test_random_traffic(420);

        write_vertex_count(gcol_pkg::VCNT_W'($urandom_range(2, 255)));
        send_idle_pct = 53;
        stall_pct     = 16;
        test_random_traffic(420);

        write_vertex_count(9'd256);
        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_traffic(420);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items (clear/add/color/read, count 0, 1, 256, 511 and random),",
                 items_sent);
        $display("%0d results: ok %0d, dup %0d, range %0d, full %0d, loop %0d; %0d mismatches",
                 results_checked, status_tally[gcol_pkg::ST_OK],
                 status_tally[gcol_pkg::ST_DUP], status_tally[gcol_pkg::ST_RANGE],
                 status_tally[gcol_pkg::ST_FULL], status_tally[gcol_pkg::ST_LOOP],
                 err_count);
        if (err_count == 0 && owed_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
